[src/wso_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wso_pkg - shared definitions for the wavetable sine oscillator
// Default sizes, register and command codes, and the sine table builder.
// ----------------------------------------------------------------------------
package wso_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 1024;
    localparam int unsigned PHASE_BITS_DEF    = 32;
    localparam int unsigned SAMPLE_BITS_DEF   = 16;

    localparam int unsigned STEP_W      = 32;
    localparam int unsigned AMP_W       = 16;
    localparam int unsigned NEW_PHASE_W = 32;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE  = 1'd1;

    localparam logic CMD_PRODUCE    = 1'b0;
    localparam logic CMD_LOAD_PHASE = 1'b1;

    localparam logic [AMP_W-1:0] AMP_RESET = 16'd16384;

    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
    localparam longint unsigned ONE_Q30    = 64'd1073741824;

    // Sine table entry i, round(sin(2*pi*i/entries) * peak), built from a
    // Q30 Taylor series on the first quarter wave and mirrored.
    function automatic longint sine_rom_entry(input int unsigned i,
                                              input int unsigned idx_bits,
                                              input int unsigned sample_bits);
        longint unsigned half;
        longint unsigned quarter;
        longint unsigned j;
        longint unsigned theta;
        longint unsigned term;
        longint unsigned sq;
        longint          sum;
        longint          peak;
        longint          v;
        half    = 64'd1 << (idx_bits - 1);
        quarter = 64'd1 << (idx_bits - 2);
        peak    = (64'sd1 <<< (sample_bits - 1)) - 64'sd1;
        j = longint'(i) & (half - 64'd1);
        if (j > quarter) begin
            j = half - j;
        end
        theta = (j * TWO_PI_Q30 + half) >> idx_bits;
        sq    = (theta * theta) >> 30;
        term  = theta;
        sum   = longint'(theta);
        term  = ((term * sq) >> 30) / 64'd6;
        sum   = sum - longint'(term);
        term  = ((term * sq) >> 30) / 64'd20;
        sum   = sum + longint'(term);
        term  = ((term * sq) >> 30) / 64'd42;
        sum   = sum - longint'(term);
        term  = ((term * sq) >> 30) / 64'd72;
        sum   = sum + longint'(term);
        term  = ((term * sq) >> 30) / 64'd110;
        sum   = sum - longint'(term);
        term  = ((term * sq) >> 30) / 64'd156;
        sum   = sum + longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        v = (sum * peak + longint'(ONE_Q30 / 2)) >>> 30;
        if (v > peak) begin
            v = peak;
        end
        if (longint'(i) >= longint'(half)) begin
            v = -v;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

[src/wavetable_sine_oscillator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wavetable_sine_oscillator - sine oscillator with table interpolation
// Phase accumulator, single-port sine ROM, linear interpolation, gain stage.
// ----------------------------------------------------------------------------
// Sequence: a produce transfer reads its table entry and the next one from the
// single-port sine ROM, then steps through states RDB, MUL, ADD, AMP and OUT.
// A transfer is taken only while idle, so a new one waits until the last sample
// is loaded into the output register; a load transfer gives no sample.
// Reset (synchronous, active low): phase zero, step zero, gain unity, no
// sample pending. The ROM is constant and needs no clearing.
// ----------------------------------------------------------------------------
module wavetable_sine_oscillator #(
    parameter int unsigned TABLE_ENTRIES = wso_pkg::TABLE_ENTRIES_DEF,
    parameter int unsigned PHASE_BITS    = wso_pkg::PHASE_BITS_DEF,
    parameter int unsigned SAMPLE_BITS   = wso_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // Configuration write port
    input  wire logic                                 i_cfg_wen,
    input  wire logic [wso_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [wso_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    // Command stream
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [wso_pkg::NEW_PHASE_W-1:0]      s_axis_tdata,  // [31:0] new_phase
    input  wire logic                                 s_axis_tuser,  // [0] command
    // Sample stream
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]          m_axis_tdata   // sample, zero padded
);
    import wso_pkg::*;

    localparam int unsigned IDXB  = $clog2(TABLE_ENTRIES);
    localparam int unsigned FRAC  = PHASE_BITS - IDXB;
    localparam int unsigned WB    = (FRAC > 16) ? 16 : FRAC;
    localparam int unsigned WBE   = (WB > 0) ? WB : 1;
    localparam int unsigned OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int unsigned DW    = SAMPLE_BITS + 1;           // entry difference
    localparam int unsigned PW    = DW + WBE + 1;              // weighted difference
    localparam int unsigned IW    = SAMPLE_BITS + 2;           // interpolated value
    localparam int unsigned SW    = IW + AMP_W;                // scaled value
    localparam int unsigned YW    = SW + 1;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDB  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_AMP  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam logic signed [YW-1:0] Y_HI = YW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [YW-1:0] Y_LO = YW'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
    localparam logic signed [PW:0]   W_RND = (PW+1)'(64'sd1 <<< (WBE - 1));
    localparam logic signed [SW:0]   A_RND = (SW+1)'(64'sd1 <<< 13);

    // Sine ROM: contents are fixed at elaboration, read synchronously.
    logic signed [SAMPLE_BITS-1:0] w_rom [TABLE_ENTRIES];
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_rom
        localparam longint ENTRY = sine_rom_entry(g, IDXB, SAMPLE_BITS);
        assign w_rom[g] = SAMPLE_BITS'(ENTRY);
    end

    logic [2:0]                    r_state, n_state;
    logic [PHASE_BITS-1:0]         r_phase;
    logic signed [STEP_W-1:0]      r_step;
    logic signed [AMP_W-1:0]       r_amp;
    logic [IDXB-1:0]               r_idx;
    logic [WBE-1:0]                r_w;
    logic [IDXB-1:0]               rom_addr;
    logic signed [SAMPLE_BITS-1:0] r_rom_q;
    logic signed [SAMPLE_BITS-1:0] r_a;
    logic signed [PW-1:0]          r_prod;
    logic signed [IW-1:0]          r_interp;
    logic signed [SW-1:0]          r_scaled;
    logic [SAMPLE_BITS-1:0]        r_sample;
    logic                          r_out_valid;

    logic                          in_xfer;
    logic                          out_load;
    logic [PHASE_BITS+31:0]        load_ext;
    logic signed [PHASE_BITS+31:0] step_ext;
    logic signed [DW-1:0]          diff;
    logic signed [PW:0]            wsum;
    logic signed [IW-1:0]          interp_next;
    logic signed [SW:0]            ysum;
    logic signed [YW-1:0]          y;
    logic signed [YW-1:0]          y_sat;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_load      = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(r_sample);

    // The loaded phase is a fraction of 2^32, aligned to the accumulator's top bit.
    assign load_ext = {s_axis_tdata, {PHASE_BITS{1'b0}}};
    assign step_ext = (PHASE_BITS + 32)'(r_step);

    // While idle the ROM is addressed by the live phase, so the first entry
    // is captured in the read register as the produce transfer is taken.
    always_comb begin
        if (r_state == S_IDLE) begin
            rom_addr = IDXB'(r_phase >> FRAC);
        end else begin
            rom_addr = r_idx + IDXB'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rom_q <= w_rom[rom_addr];
    end

    // Interpolation and gain datapath
    assign diff        = DW'(r_rom_q) - DW'(r_a);
    assign wsum        = (PW+1)'(r_prod) + W_RND;
    assign interp_next = IW'(r_a) + IW'(wsum >>> WBE);
    assign ysum        = (SW+1)'(r_scaled) + A_RND;
    assign y           = YW'(ysum >>> 14);

    always_comb begin
        if (y > Y_HI) begin
            y_sat = Y_HI;
        end else if (y < Y_LO) begin
            y_sat = Y_LO;
        end else begin
            y_sat = y;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer && (s_axis_tuser == CMD_PRODUCE)) begin
                    n_state = S_RDB;
                end
            end
            S_RDB:  n_state = S_MUL;
            S_MUL:  n_state = S_ADD;
            S_ADD:  n_state = S_AMP;
            S_AMP:  n_state = S_OUT;
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state, accumulator and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= '0;
            r_step      <= '0;
            r_amp       <= AMP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wen) begin
                case (i_cfg_idx)
                    CFG_PHASE_STEP: r_step <= i_cfg_wdata;
                    CFG_AMPLITUDE:  r_amp  <= i_cfg_wdata[AMP_W-1:0];
                    default:        ;
                endcase
            end
            if (in_xfer) begin
                if (s_axis_tuser == CMD_LOAD_PHASE) begin
                    r_phase <= PHASE_BITS'(load_ext >> 32);
                end else begin
                    // The step is applied once the current phase is captured.
                    r_phase <= r_phase + PHASE_BITS'(step_ext);
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers. Both multiplier operands are sign-extended to the
    // product width first, so the full product is kept.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_idx <= IDXB'(r_phase >> FRAC);
            r_w   <= (WB == 0) ? '0 : WBE'(r_phase >> (FRAC - WB));
        end
        if (r_state == S_RDB) begin
            r_a <= r_rom_q;
        end
        if (r_state == S_MUL) begin
            r_prod <= PW'(diff) * PW'($signed({1'b0, r_w}));
        end
        if (r_state == S_ADD) begin
            r_interp <= interp_next;
        end
        if (r_state == S_AMP) begin
            r_scaled <= SW'(r_interp) * SW'(r_amp);
        end
        if (out_load) begin
            r_sample <= SAMPLE_BITS'(y_sat);
        end
    end

endmodule
`default_nettype wire
